>>> hw/rtl/enbid_pkg.sv
// ----------------------------------------------------------------------------
// enbid_pkg
// Shared types and status codes of the build-id note extractor.
// ----------------------------------------------------------------------------
package enbid_pkg;

  // One byte of the notes section, with the marker on the final byte.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_section;
  } enbid_in_t;

  // One result word.
  typedef struct packed {
    logic [7:0] id_byte;
    logic [1:0] status;
    logic       last_of_id;
  } enbid_out_t;

  // Result status codes.
  localparam logic [1:0] StatusId    = 2'd0;
  localparam logic [1:0] StatusEmpty = 2'd1;
  localparam logic [1:0] StatusNone  = 2'd2;

endpackage

>>> hw/rtl/enbid_in_stage.sv
// ----------------------------------------------------------------------------
// enbid_in_stage
// Input register that holds one section byte until the parser takes it.
// ----------------------------------------------------------------------------
module enbid_in_stage
  import enbid_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  enbid_in_t in_data_i,
  input  logic      adv_i,
  output logic      vld_o,
  output enbid_in_t data_o
);

  logic      vld_q;
  enbid_in_t data_q;
  logic      load;

  // The register can be refilled when it is empty or drains this cycle.
  assign load       = ~vld_q | adv_i;
  assign in_stall_o = ~load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

>>> hw/rtl/enbid_parser.sv
// ----------------------------------------------------------------------------
// enbid_parser
// Note walker: header assembly, name check, skip counter and id emission.
// ----------------------------------------------------------------------------
module enbid_parser
  import enbid_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  enbid_in_t  item_i,
  input  logic       big_endian_i,
  output logic       res_vld_o,
  output enbid_out_t res_o
);

  typedef enum logic [4:0] {
    PhHeader = 5'b00001,
    PhName   = 5'b00010,
    PhSkip   = 5'b00100,
    PhDesc   = 5'b01000,
    PhDone   = 5'b10000
  } phase_e;

  localparam logic [3:0]  LastHdrIdx   = 4'd11;
  localparam logic [31:0] NoteNameSize = 32'd4;
  localparam logic [31:0] NoteTypeId   = 32'd3;

  function automatic logic [31:0] pad4(input logic [31:0] v);
    logic [31:0] s;
    s = v + 32'd3;
    return {s[31:2], 2'b00};
  endfunction

  function automatic logic [7:0] gnu_char(input logic [1:0] k);
    logic [7:0] c;
    case (k)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h4E;
      2'd2:    c = 8'h55;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] add_byte(input logic [31:0] word, input logic [1:0] pos,
                                           input logic [7:0] b, input logic be);
    logic [31:0] base;
    base = (pos == 2'd0) ? 32'd0 : word;
    if (be) begin
      return {base[23:0], b};
    end
    return base | (32'(b) << {pos, 3'b000});
  endfunction

  phase_e      phase_q, phase_d;
  logic [3:0]  hidx_q, hidx_d;
  logic [31:0] name_len_q, name_len_d;
  logic [31:0] desc_len_q, desc_len_d;
  logic [31:0] kind_q, kind_d;
  logic        name_ok_q, name_ok_d;
  logic [33:0] skip_q, skip_d;
  logic [31:0] desc_rem_q, desc_rem_d;

  logic [33:0] skip_len;
  logic [31:0] dr;
  logic        was_done;
  logic        match;
  logic [7:0]  b;
  logic        eos;

  assign b   = item_i.data_byte;
  assign eos = item_i.end_of_section;

  always_comb begin
    phase_d    = phase_q;
    hidx_d     = hidx_q;
    name_len_d = name_len_q;
    desc_len_d = desc_len_q;
    kind_d     = kind_q;
    name_ok_d  = name_ok_q;
    skip_d     = skip_q;
    desc_rem_d = desc_rem_q;
    res_vld_o  = 1'b0;
    res_o      = '0;
    was_done   = (phase_q == PhDone);
    skip_len   = '0;
    dr         = pad4(desc_len_q);
    match      = name_ok_q & (b == gnu_char(hidx_q[1:0]));

    unique case (phase_q)
      PhHeader: begin
        case (hidx_q[3:2])
          2'd0:    name_len_d = add_byte(name_len_q, hidx_q[1:0], b, big_endian_i);
          2'd1:    desc_len_d = add_byte(desc_len_q, hidx_q[1:0], b, big_endian_i);
          default: kind_d     = add_byte(kind_q, hidx_q[1:0], b, big_endian_i);
        endcase
        hidx_d = hidx_q + 4'd1;
        if (hidx_q == LastHdrIdx) begin
          if (name_len_q == NoteNameSize && kind_d == NoteTypeId) begin
            phase_d   = PhName;
            name_ok_d = 1'b1;
          end else begin
            skip_len = {2'b00, pad4(name_len_q)} + {2'b00, pad4(desc_len_q)};
            if (skip_len == '0) begin
              phase_d = PhHeader;
              hidx_d  = '0;
            end else begin
              phase_d = PhSkip;
              skip_d  = skip_len;
            end
          end
        end
      end
      PhName: begin
        name_ok_d = match;
        hidx_d    = hidx_q + 4'd1;
        if (hidx_q[1:0] == 2'd3) begin
          if (match) begin
            desc_rem_d = (dr == '0) ? '0 : desc_len_q;
            if (desc_rem_d == '0 || eos) begin
              res_vld_o        = 1'b1;
              res_o.status     = StatusEmpty;
              res_o.last_of_id = 1'b1;
              phase_d          = PhDone;
            end else begin
              phase_d = PhDesc;
            end
          end else if (dr == '0) begin
            phase_d = PhHeader;
            hidx_d  = '0;
          end else begin
            phase_d = PhSkip;
            skip_d  = {2'b00, dr};
          end
        end
      end
      PhSkip: begin
        skip_d = skip_q - 34'd1;
        if (skip_d == '0) begin
          phase_d = PhHeader;
          hidx_d  = '0;
        end
      end
      PhDesc: begin
        res_vld_o     = 1'b1;
        res_o.id_byte = b;
        res_o.status  = StatusId;
        desc_rem_d    = desc_rem_q - 32'd1;
        if (desc_rem_d == '0 || eos) begin
          res_o.last_of_id = 1'b1;
          phase_d          = PhDone;
        end
      end
      PhDone: begin
      end
      default: begin
        phase_d    = PhHeader;
        hidx_d     = '0;
        name_len_d = '0;
        desc_len_d = '0;
        kind_d     = '0;
        name_ok_d  = 1'b1;
        skip_d     = '0;
        desc_rem_d = '0;
      end
    endcase

    // Section end: report a missing id if nothing else was said, then restart.
    if (eos) begin
      if (!res_vld_o && !was_done) begin
        res_vld_o        = 1'b1;
        res_o            = '0;
        res_o.status     = StatusNone;
        res_o.last_of_id = 1'b1;
      end
      phase_d    = PhHeader;
      hidx_d     = '0;
      name_len_d = '0;
      desc_len_d = '0;
      kind_d     = '0;
      name_ok_d  = 1'b1;
      skip_d     = '0;
      desc_rem_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHeader;
      hidx_q     <= '0;
      name_len_q <= '0;
      desc_len_q <= '0;
      kind_q     <= '0;
      name_ok_q  <= 1'b1;
      skip_q     <= '0;
      desc_rem_q <= '0;
    end else if (en_i) begin
      phase_q    <= phase_d;
      hidx_q     <= hidx_d;
      name_len_q <= name_len_d;
      desc_len_q <= desc_len_d;
      kind_q     <= kind_d;
      name_ok_q  <= name_ok_d;
      skip_q     <= skip_d;
      desc_rem_q <= desc_rem_d;
    end
  end

endmodule

>>> hw/rtl/elf_note_build_id_extractor.sv
// ----------------------------------------------------------------------------
// elf_note_build_id_extractor
// Streams an ELF notes section and returns the GNU build id it carries.
// ----------------------------------------------------------------------------
// The input channel carries one section byte per word, with end_of_section set
// on the final byte. The output channel carries build id bytes (status 0),
// a single status 1 word for a matching note with an empty id, or a single
// status 2 word when the section held no id. last_of_id marks the final word
// of a section. Both channels use valid and stall; a word moves on a clock
// edge with valid high and stall low.
// An accepted byte is held in the input register and is parsed on the way
// into the output register, which presents its result on out_data_o. One byte
// is taken every cycle as long as the output side keeps draining; the input
// register and the output register decouple the two ends.
// When the receiver stalls, the result is held. A byte already waiting in the
// input register stays there and in_stall_o rises in the same cycle; an empty
// input register still takes one more byte first.
// Reset clears both registers and the note walker and sets the byte order to
// little endian. The user writes the byte order register through cfg_we_i and
// cfg_wdata_i only while no section is in flight; the block does not check it.
// ----------------------------------------------------------------------------
module elf_note_build_id_extractor
  import enbid_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  enbid_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output enbid_out_t out_data_o,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);

  logic       big_endian_q;
  logic       in_vld;
  enbid_in_t  in_item;
  logic       adv;
  logic       res_vld;
  enbid_out_t res;
  logic       out_vld_q;
  enbid_out_t out_data_q;

  // Byte order of the header words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_endian_q <= 1'b0;
    end else if (cfg_we_i) begin
      big_endian_q <= cfg_wdata_i;
    end
  end

  // A held byte is parsed whenever the output register is free or drains now.
  assign adv = in_vld & (~out_vld_q | ~out_stall_i);

  enbid_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .adv_i      (adv),
    .vld_o      (in_vld),
    .data_o     (in_item)
  );

  enbid_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (adv),
    .item_i       (in_item),
    .big_endian_i (big_endian_q),
    .res_vld_o    (res_vld),
    .res_o        (res)
  );

  // Output register. A parsed byte that gives no result leaves it empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= res_vld;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_vld) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // The input side only backs up when the output side is stalled with a word.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && in_vld))
    else $error("input stalled without a stalled output word");

  // Status words are always the final word and carry a zero byte.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != StatusId) |->
      (out_data_o.last_of_id && out_data_o.id_byte == 8'd0))
    else $error("status word without last_of_id or with nonzero byte");

  // No undefined status code is ever produced.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == StatusId || out_data_o.status == StatusEmpty ||
                     out_data_o.status == StatusNone))
    else $error("undefined status code");

  // A word that drains with nothing parsed behind it leaves the output empty.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !in_vld) |=> !out_valid_o)
    else $error("output word repeated");
`endif

endmodule
